/* rtl/gfc_pkg.sv */
// Shared constants, types and command format for the GIF frame compositor.
package gfc_pkg;

	localparam int MAX_WIDTH    = 256;
	localparam int MAX_HEIGHT   = 256;
	localparam int PALETTE_SIZE = 256;
	localparam int CELLS        = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W       = $clog2(CELLS);
	localparam int XW           = $clog2(MAX_WIDTH + 1);
	localparam int YW           = $clog2(MAX_HEIGHT + 1);
	localparam int PAL_AW       = $clog2(PALETTE_SIZE);
	localparam int CFG_W        = 9;
	localparam int CFG_IDX_W    = 8;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);
	localparam int IN_DATA_W    = 120;
	localparam int IN_USER_W    = 3;
	localparam int OUT_DATA_W   = 80;
	localparam int OUT_USER_W   = 2;

	localparam logic [2:0] ACT_START   = 3'd0;
	localparam logic [2:0] ACT_PALETTE = 3'd1;
	localparam logic [2:0] ACT_BEGIN   = 3'd2;
	localparam logic [2:0] ACT_PIXEL   = 3'd3;
	localparam logic [2:0] ACT_READ    = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_OFF_CANVAS = 2'd1;
	localparam logic [1:0] ST_FRAME_FULL = 2'd2;
	localparam logic [1:0] ST_NO_FRAME   = 2'd3;

	localparam logic [2:0] DISP_CLEAR   = 3'd2;
	localparam logic [2:0] DISP_RESTORE = 3'd3;

	localparam logic [9:0] DELAY_DEFAULT = 10'd10;
	localparam logic [9:0] DELAY_MAX     = 10'd1000;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 8'd1;

	typedef enum logic [2:0] {
		CMD_START,
		CMD_PALETTE,
		CMD_BEGIN,
		CMD_PIXEL,
		CMD_READ,
		CMD_NONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  cidx;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fw;
		logic [15:0] fh;
		logic [2:0]  disp;
		logic        ten;
		logic [9:0]  dur;
	} cmd_t;

endpackage

/* rtl/gif_frame_compositor_core.sv */
// Top level of the GIF frame compositor: configuration registers and front/back wiring.
// The block composes GIF animation frames on a 256 x 256 RGBA canvas held in on-chip
// memory, with a second memory for the disposal snapshot and a 256-entry palette.
// Commands enter through a two-entry queue and run one at a time in the back end:
// palette writes and invalid actions complete when popped, while frame pixels and canvas
// reads first do one palette or canvas memory read, then the write or result.
// Opening a frame may walk the canvas one pixel per cycle: a clear-to-transparent
// disposal covers each pixel of the clipped rectangle, a restore and a snapshot
// each cover the whole canvas. Starting an image clears the whole canvas. After
// reset a clearing pass of the whole canvas runs with s_tready held low.
// cfg_ready is high only while the command queue is empty and the back end is idle,
// so a configuration write never lands while a transaction is in flight.
module gif_frame_compositor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// color_index, red, green, blue, frame_x, frame_y, frame_w, frame_h,
	// disposal_mode, transparent_enable, delay_cs, zero fill
	input  logic [gfc_pkg::IN_DATA_W-1:0]     s_tdata,
	// action
	input  logic [gfc_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_red, out_green, out_blue, out_alpha, frame_duration_cs, elapsed_cs, zero fill
	output logic [gfc_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status
	output logic [gfc_pkg::OUT_USER_W-1:0]    m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gfc_pkg::CFG_W-1:0]         cfg_data
);

	logic [gfc_pkg::CFG_W-1:0] width_q;
	logic [gfc_pkg::CFG_W-1:0] height_q;
	logic [gfc_pkg::XW-1:0]    eff_w;
	logic [gfc_pkg::YW-1:0]    eff_h;
	logic                      hold;
	logic                      back_idle;
	logic                      cmd_valid;
	logic                      cmd_pop;
	gfc_pkg::cmd_t             cmd;

	assign cfg_ready = back_idle && !cmd_valid;

	always_comb begin
		priority if (width_q == '0) begin
			eff_w = gfc_pkg::XW'(1);
		end else if (32'(width_q) > 32'(gfc_pkg::MAX_WIDTH)) begin
			eff_w = gfc_pkg::XW'(gfc_pkg::MAX_WIDTH);
		end else begin
			eff_w = gfc_pkg::XW'(width_q);
		end
		priority if (height_q == '0) begin
			eff_h = gfc_pkg::YW'(1);
		end else if (32'(height_q) > 32'(gfc_pkg::MAX_HEIGHT)) begin
			eff_h = gfc_pkg::YW'(gfc_pkg::MAX_HEIGHT);
		end else begin
			eff_h = gfc_pkg::YW'(height_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gfc_pkg::CFG_W'(256);
			height_q <= gfc_pkg::CFG_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == gfc_pkg::CFG_WIDTH_IDX) begin
				width_q <= cfg_data;
			end else if (cfg_index == gfc_pkg::CFG_HEIGHT_IDX) begin
				height_q <= cfg_data;
			end
		end
	end

	gfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (hold),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	gfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.init_busy (hold),
		.idle      (back_idle),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* rtl/gfc_front.sv */
// Front end: accepts input transactions, classifies them and queues commands.
module gfc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            hold,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// color_index, red, green, blue, frame_x, frame_y, frame_w, frame_h,
	// disposal_mode, transparent_enable, delay_cs, zero fill
	input  logic [gfc_pkg::IN_DATA_W-1:0]   s_tdata,
	// action
	input  logic [gfc_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                            cmd_valid,
	input  logic                            cmd_pop,
	output gfc_pkg::cmd_t                   cmd
);

	gfc_pkg::cmd_t               new_cmd;
	gfc_pkg::cmd_t               queue_q [gfc_pkg::QDEPTH];
	logic [gfc_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [gfc_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [gfc_pkg::QCNT_W-1:0]  cnt_q;
	logic                        push;
	logic [15:0]                 delay;

	assign s_tready  = !hold && (cnt_q < gfc_pkg::QCNT_W'(gfc_pkg::QDEPTH));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign delay     = s_tdata[115:100];

	always_comb begin
		unique case (s_tuser)
			gfc_pkg::ACT_START:   new_cmd.kind = gfc_pkg::CMD_START;
			gfc_pkg::ACT_PALETTE: new_cmd.kind = gfc_pkg::CMD_PALETTE;
			gfc_pkg::ACT_BEGIN:   new_cmd.kind = gfc_pkg::CMD_BEGIN;
			gfc_pkg::ACT_PIXEL:   new_cmd.kind = gfc_pkg::CMD_PIXEL;
			gfc_pkg::ACT_READ:    new_cmd.kind = gfc_pkg::CMD_READ;
			default:              new_cmd.kind = gfc_pkg::CMD_NONE;
		endcase
		new_cmd.cidx  = s_tdata[7:0];
		new_cmd.red   = s_tdata[15:8];
		new_cmd.green = s_tdata[23:16];
		new_cmd.blue  = s_tdata[31:24];
		new_cmd.fx    = s_tdata[47:32];
		new_cmd.fy    = s_tdata[63:48];
		new_cmd.fw    = s_tdata[79:64];
		new_cmd.fh    = s_tdata[95:80];
		new_cmd.disp  = s_tdata[98:96];
		new_cmd.ten   = s_tdata[99];
		priority if (delay == 16'd0) begin
			new_cmd.dur = gfc_pkg::DELAY_DEFAULT;
		end else if (delay > 16'(gfc_pkg::DELAY_MAX)) begin
			new_cmd.dur = gfc_pkg::DELAY_MAX;
		end else begin
			new_cmd.dur = delay[9:0];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == gfc_pkg::QPTR_W'(gfc_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == gfc_pkg::QPTR_W'(gfc_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/gfc_back.sv */
// Back end: canvas, snapshot and palette memories, sweep sequencer and result register.
module gfc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [gfc_pkg::XW-1:0]           eff_w,
	input  logic [gfc_pkg::YW-1:0]           eff_h,
	input  logic                             cmd_valid,
	input  gfc_pkg::cmd_t                    cmd,
	output logic                             cmd_pop,
	output logic                             init_busy,
	output logic                             idle,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_red, out_green, out_blue, out_alpha, frame_duration_cs, elapsed_cs, zero fill
	output logic [gfc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status
	output logic [gfc_pkg::OUT_USER_W-1:0]   m_tuser
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_RESTORE,
		S_SNAP,
		S_DRAIN,
		S_PIXW,
		S_READ
	} state_t;

	function automatic logic [gfc_pkg::ADDR_W-1:0] cell_addr(input logic [15:0] x,
		input logic [15:0] y);
		logic [31:0] a;
		a = 32'(y) * 32'(gfc_pkg::MAX_WIDTH) + 32'(x);
		return a[gfc_pkg::ADDR_W-1:0];
	endfunction

	logic [31:0] canvas_mem [gfc_pkg::CELLS];
	logic [31:0] snap_mem [gfc_pkg::CELLS];
	logic [23:0] pal_mem [gfc_pkg::PALETTE_SIZE];
	logic [31:0] canvas_rd_q;
	logic [31:0] snap_rd_q;
	logic [23:0] pal_rd_q;

	state_t                     state_q;
	logic                       init_q;
	logic                       snap_valid_q;
	logic                       has_prev_q;
	logic [15:0]                prev_x_q, prev_y_q, prev_w_q, prev_h_q;
	logic [2:0]                 prev_disp_q;
	logic [15:0]                cur_x_q, cur_y_q, cur_w_q, cur_h_q;
	logic [7:0]                 cur_tidx_q;
	logic                       cur_ten_q;
	logic                       open_q;
	logic [15:0]                lx_q, ly_q;
	logic [31:0]                elapsed_q;
	logic [gfc_pkg::XW-1:0]     cx_q, x0_q, x1_q;
	logic [gfc_pkg::YW-1:0]     cy_q, y1_q;
	logic [gfc_pkg::ADDR_W-1:0] cnt_q;
	logic                       snap_pend_q;
	logic                       cpw_s1;
	logic                       cpw_snap_s1;
	logic [gfc_pkg::ADDR_W-1:0] cpw_addr_s1;
	logic                       pw_en_q;
	logic                       pw_black_q;
	logic [gfc_pkg::ADDR_W-1:0] pw_addr_q;
	logic                       out_valid_q;
	logic [7:0]                 o_red_q, o_green_q, o_blue_q, o_alpha_q;
	logic [9:0]                 o_dur_q;
	logic [31:0]                o_ela_q;
	logic [1:0]                 o_status_q;

	logic [16:0]                px_end, py_end;
	logic [gfc_pkg::XW-1:0]     x0c, x1c;
	logic [gfc_pkg::YW-1:0]     y0c, y1c;
	logic                       rect_ok;
	logic                       pix_done;
	logic [16:0]                pcx, pcy;
	logic                       pix_on;
	logic                       pix_trans;
	logic                       rd_on;
	logic [32:0]                ela_sum;
	logic [31:0]                ela_new;
	logic                       can_we;
	logic [gfc_pkg::ADDR_W-1:0] can_waddr;
	logic [31:0]                can_wdata;
	logic [gfc_pkg::ADDR_W-1:0] can_raddr;
	logic                       pal_we;

	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid && (!out_valid_q || m_tready);
	assign init_busy = init_q;
	assign idle      = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'd0, o_ela_q, o_dur_q, o_alpha_q, o_blue_q, o_green_q, o_red_q};
	assign m_tuser   = o_status_q;

	always_comb begin
		px_end  = 17'(prev_x_q) + 17'(prev_w_q);
		py_end  = 17'(prev_y_q) + 17'(prev_h_q);
		x0c     = (prev_x_q > 16'(eff_w)) ? eff_w : prev_x_q[gfc_pkg::XW-1:0];
		x1c     = (px_end > 17'(eff_w)) ? eff_w : px_end[gfc_pkg::XW-1:0];
		y0c     = (prev_y_q > 16'(eff_h)) ? eff_h : prev_y_q[gfc_pkg::YW-1:0];
		y1c     = (py_end > 17'(eff_h)) ? eff_h : py_end[gfc_pkg::YW-1:0];
		rect_ok = (x0c < x1c) && (y0c < y1c);

		pix_done  = (cur_w_q == 16'd0) || (ly_q >= cur_h_q);
		pcx       = 17'(cur_x_q) + 17'(lx_q);
		pcy       = 17'(cur_y_q) + 17'(ly_q);
		pix_on    = (pcx < 17'(eff_w)) && (pcy < 17'(eff_h));
		pix_trans = cur_ten_q && (cmd.cidx == cur_tidx_q);
		rd_on     = (cmd.fx < 16'(eff_w)) && (cmd.fy < 16'(eff_h));

		ela_sum = 33'(elapsed_q) + 33'(cmd.dur);
		ela_new = ela_sum[32] ? '1 : ela_sum[31:0];
	end

	always_comb begin
		can_we    = 1'b0;
		can_waddr = pw_addr_q;
		can_wdata = '0;
		priority if (state_q == S_CLEAR) begin
			can_we    = 1'b1;
			can_waddr = cell_addr(16'(cx_q), 16'(cy_q));
		end else if (cpw_s1 && !cpw_snap_s1) begin
			can_we    = 1'b1;
			can_waddr = cpw_addr_s1;
			can_wdata = snap_rd_q;
		end else if (state_q == S_PIXW && pw_en_q) begin
			can_we    = 1'b1;
			can_wdata = pw_black_q ? {24'd0, gfc_pkg::ALPHA_OPAQUE}
				: {pal_rd_q, gfc_pkg::ALPHA_OPAQUE};
		end else begin
			can_we = 1'b0;
		end
		can_raddr = (state_q == S_SNAP) ? cnt_q : cell_addr(cmd.fx, cmd.fy);
		pal_we    = cmd_pop && (cmd.kind == gfc_pkg::CMD_PALETTE)
			&& (9'(cmd.cidx) < 9'(gfc_pkg::PALETTE_SIZE));
	end

	always_ff @(posedge clk) begin
		if (can_we) begin
			canvas_mem[can_waddr] <= can_wdata;
		end
		canvas_rd_q <= canvas_mem[can_raddr];
	end

	always_ff @(posedge clk) begin
		if (cpw_s1 && cpw_snap_s1) begin
			snap_mem[cpw_addr_s1] <= canvas_rd_q;
		end
		snap_rd_q <= snap_mem[cnt_q];
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[cmd.cidx[gfc_pkg::PAL_AW-1:0]] <= {cmd.red, cmd.green, cmd.blue};
		end
		pal_rd_q <= pal_mem[cmd.cidx[gfc_pkg::PAL_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			init_q       <= 1'b1;
			snap_valid_q <= 1'b0;
			has_prev_q   <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_w_q     <= '0;
			prev_h_q     <= '0;
			prev_disp_q  <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			cur_w_q      <= '0;
			cur_h_q      <= '0;
			cur_tidx_q   <= '0;
			cur_ten_q    <= 1'b0;
			open_q       <= 1'b0;
			lx_q         <= '0;
			ly_q         <= '0;
			elapsed_q    <= '0;
			cx_q         <= '0;
			x0_q         <= '0;
			x1_q         <= gfc_pkg::XW'(gfc_pkg::MAX_WIDTH);
			cy_q         <= '0;
			y1_q         <= gfc_pkg::YW'(gfc_pkg::MAX_HEIGHT);
			cnt_q        <= '0;
			snap_pend_q  <= 1'b0;
			cpw_s1       <= 1'b0;
			cpw_snap_s1  <= 1'b0;
			cpw_addr_s1  <= '0;
			pw_en_q      <= 1'b0;
			pw_black_q   <= 1'b0;
			pw_addr_q    <= '0;
			out_valid_q  <= 1'b0;
			o_red_q      <= '0;
			o_green_q    <= '0;
			o_blue_q     <= '0;
			o_alpha_q    <= '0;
			o_dur_q      <= '0;
			o_ela_q      <= '0;
			o_status_q   <= '0;
		end else begin
			cpw_s1 <= 1'b0;
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						out_valid_q <= 1'b1;
						o_red_q     <= '0;
						o_green_q   <= '0;
						o_blue_q    <= '0;
						o_alpha_q   <= '0;
						o_dur_q     <= '0;
						o_ela_q     <= '0;
						o_status_q  <= gfc_pkg::ST_OK;
						unique case (cmd.kind)
							gfc_pkg::CMD_START: begin
								snap_valid_q <= 1'b0;
								has_prev_q   <= 1'b0;
								prev_x_q     <= '0;
								prev_y_q     <= '0;
								prev_w_q     <= '0;
								prev_h_q     <= '0;
								prev_disp_q  <= '0;
								cur_x_q      <= '0;
								cur_y_q      <= '0;
								cur_w_q      <= '0;
								cur_h_q      <= '0;
								cur_tidx_q   <= '0;
								cur_ten_q    <= 1'b0;
								open_q       <= 1'b0;
								lx_q         <= '0;
								ly_q         <= '0;
								elapsed_q    <= '0;
								cx_q         <= '0;
								x0_q         <= '0;
								x1_q         <= gfc_pkg::XW'(gfc_pkg::MAX_WIDTH);
								cy_q         <= '0;
								y1_q         <= gfc_pkg::YW'(gfc_pkg::MAX_HEIGHT);
								snap_pend_q  <= 1'b0;
								state_q      <= S_CLEAR;
							end
							gfc_pkg::CMD_BEGIN: begin
								elapsed_q    <= ela_new;
								o_dur_q      <= cmd.dur;
								o_ela_q      <= ela_new;
								cur_x_q      <= cmd.fx;
								cur_y_q      <= cmd.fy;
								cur_w_q      <= cmd.fw;
								cur_h_q      <= cmd.fh;
								cur_tidx_q   <= cmd.cidx;
								cur_ten_q    <= cmd.ten;
								prev_x_q     <= cmd.fx;
								prev_y_q     <= cmd.fy;
								prev_w_q     <= cmd.fw;
								prev_h_q     <= cmd.fh;
								prev_disp_q  <= cmd.disp;
								has_prev_q   <= 1'b1;
								open_q       <= 1'b1;
								lx_q         <= '0;
								ly_q         <= '0;
								snap_valid_q <= (cmd.disp == gfc_pkg::DISP_RESTORE);
								snap_pend_q  <= (cmd.disp == gfc_pkg::DISP_RESTORE);
								cnt_q        <= '0;
								priority if (has_prev_q && prev_disp_q == gfc_pkg::DISP_CLEAR
									&& rect_ok) begin
									cx_q    <= x0c;
									x0_q    <= x0c;
									x1_q    <= x1c;
									cy_q    <= y0c;
									y1_q    <= y1c;
									state_q <= S_CLEAR;
								end else if (has_prev_q && prev_disp_q == gfc_pkg::DISP_RESTORE
									&& snap_valid_q) begin
									state_q <= S_RESTORE;
								end else if (cmd.disp == gfc_pkg::DISP_RESTORE) begin
									snap_pend_q <= 1'b0;
									state_q     <= S_SNAP;
								end else begin
									state_q <= S_IDLE;
								end
							end
							gfc_pkg::CMD_PIXEL: begin
								priority if (!open_q) begin
									o_status_q <= gfc_pkg::ST_NO_FRAME;
								end else if (pix_done) begin
									o_status_q <= gfc_pkg::ST_FRAME_FULL;
								end else begin
									if (lx_q == cur_w_q - 16'd1) begin
										lx_q <= '0;
										ly_q <= ly_q + 16'd1;
									end else begin
										lx_q <= lx_q + 16'd1;
									end
									pw_en_q    <= pix_on && !pix_trans;
									pw_addr_q  <= cell_addr(pcx[15:0], pcy[15:0]);
									pw_black_q <= (9'(cmd.cidx) >= 9'(gfc_pkg::PALETTE_SIZE));
									state_q    <= S_PIXW;
								end
							end
							gfc_pkg::CMD_READ: begin
								if (rd_on) begin
									out_valid_q <= 1'b0;
									state_q     <= S_READ;
								end else begin
									o_status_q <= gfc_pkg::ST_OFF_CANVAS;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CLEAR: begin
					if (cx_q == x1_q - 1'b1) begin
						cx_q <= x0_q;
						if (cy_q == y1_q - 1'b1) begin
							init_q      <= 1'b0;
							cnt_q       <= '0;
							snap_pend_q <= 1'b0;
							state_q     <= snap_pend_q ? S_SNAP : S_IDLE;
						end else begin
							cy_q <= cy_q + 1'b1;
						end
					end else begin
						cx_q <= cx_q + 1'b1;
					end
				end
				S_RESTORE, S_SNAP: begin
					cpw_s1      <= 1'b1;
					cpw_snap_s1 <= (state_q == S_SNAP);
					cpw_addr_s1 <= cnt_q;
					cnt_q       <= cnt_q + 1'b1;
					if (cnt_q == gfc_pkg::ADDR_W'(gfc_pkg::CELLS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					cnt_q <= '0;
					if (snap_pend_q) begin
						snap_pend_q <= 1'b0;
						state_q     <= S_SNAP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PIXW: begin
					state_q <= S_IDLE;
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					o_red_q     <= canvas_rd_q[31:24];
					o_green_q   <= canvas_rd_q[23:16];
					o_blue_q    <= canvas_rd_q[15:8];
					o_alpha_q   <= canvas_rd_q[7:0];
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
